### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFHA_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("allocator assertion failed");

// Next-cycle implication, checked out of reset.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("allocator assertion failed");

`endif

### design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Types, codes and defaults shared by the heap allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int HEADER_BYTES_DEF = 16;
	localparam logic [31:0] HEAP_SIZE_RST = 32'd65536;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_FIT    = 2'd1,
		STS_NOT_ALLOC = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_HEAP_BASE = 2'd0,
		CFG_HEAP_SIZE = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_PICK,
		S_APPLY
	} state_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_MATCH,
		CM_APPLY,
		CM_REBUILD
	} cell_mode_t;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] size;
		logic        used;
	} seg_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_mode_t  mode;
		cmd_t        cmd;
		logic [31:0] req;
		logic [31:0] key;
		logic [31:0] off_new;
		logic [31:0] size_new;
		logic [31:0] size_merged;
		logic        split;
		logic        mprev;
		logic        mnext;
	} cell_bc_t;

endpackage

`default_nettype wire

### design/ffha_ifs.sv
// ----------------------------------------------------------------------------
// Allocator channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] request_size;
	logic [31:0] free_address;
	modport source (output valid, command, request_size, free_address, input ready);
	modport sink (input valid, command, request_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_address;
	logic [1:0]  status;
	modport source (output valid, result_address, status, input ready);
	modport sink (input valid, result_address, status, output ready);
endinterface

interface ffha_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/ffha_cell.sv
// ----------------------------------------------------------------------------
// Segment cell
// Holds one table entry, flags a match and shifts entries for insert and merge.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_cell #(
	parameter int          IDX      = 0,
	parameter int          IW       = 6,
	parameter int          CW       = 7,
	parameter logic [31:0] RST_SIZE = 32'd65520
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffha_pkg::cell_bc_t bc,
	input  logic [IW-1:0]     idx,
	input  logic [CW-1:0]     count,
	input  ffha_pkg::seg_t    prev,
	input  ffha_pkg::seg_t    next1,
	input  ffha_pkg::seg_t    next2,
	output ffha_pkg::seg_t    seg,
	output logic              hit
);
	import ffha_pkg::*;

	seg_t seg_q, seg_d;
	logic hit_q, hit_d;
	logic valid, is_i, is_im1, is_ip1, above_i, above_ip1, from_i;

	always_comb begin
		valid     = CW'(IDX) < count;
		is_i      = (IDX == int'(idx));
		is_im1    = (IDX + 1 == int'(idx));
		is_ip1    = (IDX == int'(idx) + 1);
		above_i   = (IDX > int'(idx));
		above_ip1 = (IDX > int'(idx) + 1);
		from_i    = (IDX >= int'(idx));
		seg_d = seg_q;
		hit_d = hit_q;
		case (bc.mode)
			CM_MATCH: begin
				if (bc.cmd == CMD_ALLOC)
					hit_d = valid && !seg_q.used && (seg_q.size > bc.req);
				else
					hit_d = valid && seg_q.used && (seg_q.offset == bc.key);
			end
			CM_APPLY: begin
				if (bc.cmd == CMD_ALLOC) begin
					if (is_i) begin
						seg_d.used = 1'b1;
						if (bc.split)
							seg_d.size = bc.req;
					end else if (bc.split && is_ip1) begin
						seg_d.offset = bc.off_new;
						seg_d.size   = bc.size_new;
						seg_d.used   = 1'b0;
					end else if (bc.split && above_ip1) begin
						seg_d = prev;
					end
				end else if (bc.mprev) begin
					// The left neighbour absorbs the freed entry, the rest close up.
					if (is_im1)
						seg_d.size = bc.size_merged;
					else if (from_i)
						seg_d = bc.mnext ? next2 : next1;
				end else if (bc.mnext) begin
					if (is_i) begin
						seg_d.size = bc.size_merged;
						seg_d.used = 1'b0;
					end else if (above_i) begin
						seg_d = next1;
					end
				end else if (is_i) begin
					seg_d.used = 1'b0;
				end
			end
			CM_REBUILD: begin
				if (IDX == 0) begin
					seg_d.offset = '0;
					seg_d.size   = bc.size_new;
					seg_d.used   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q.offset <= '0;
			seg_q.size   <= (IDX == 0) ? RST_SIZE : '0;
			seg_q.used   <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			seg_q <= seg_d;
			hit_q <= hit_d;
		end
	end

	assign seg = seg_q;
	assign hit = hit_q;

endmodule

`default_nettype wire

### design/ffha_pick.sv
// ----------------------------------------------------------------------------
// First-hit picker
// Isolates the lowest flagged cell and gathers it and its two neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_pick #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  logic [N-1:0]   hits,
	input  ffha_pkg::seg_t segs [N],
	output logic           found,
	output logic [IW-1:0]  idx,
	output ffha_pkg::seg_t seg_i,
	output ffha_pkg::seg_t seg_prev,
	output ffha_pkg::seg_t seg_next
);
	import ffha_pkg::*;

	logic [N-1:0] first;

	always_comb begin
		first    = hits & (~hits + N'(1));
		found    = |hits;
		idx      = '0;
		seg_i    = '0;
		seg_prev = '0;
		seg_next = '0;
		for (int k = 0; k < N; k++) begin
			if (first[k]) begin
				idx   = idx | IW'(k);
				seg_i = seg_i | segs[k];
			end
		end
		for (int k = 1; k < N; k++)
			if (first[k])
				seg_prev = seg_prev | segs[k-1];
		for (int k = 0; k < N - 1; k++)
			if (first[k])
				seg_next = seg_next | segs[k+1];
	end

endmodule

`default_nettype wire

### design/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Segment table kept in a row of cells, with first-fit allocate and
// coalescing free.
// ----------------------------------------------------------------------------
// Requests arrive on req: command 0 allocates request_size bytes, command 1
// frees the block whose payload address is free_address. Each request gives
// exactly one response transfer on rsp with result_address and status.
// The cfg channel writes heap_base (index 0) or heap_size (index 1); either
// write rebuilds the table as one free segment in the same cycle. It is
// always ready; the user must write it only while no request is in flight,
// and the block itself does not enforce this. A request is matched in
// every cell at once, the lowest hit is picked and registered, then the
// cells shift in one step; the response is registered in that apply step.
// A new request is taken only after the apply step of the last one.
// A response held by rsp.ready low keeps its register; the next request is
// still accepted and waits in its apply step until the register is free.
// Reset clears the table to one free segment of 65536 bytes less a header
// at offset zero, with heap_base zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module first_fit_heap_allocator #(
	parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ffha_req_if.sink     req,
	ffha_rsp_if.source   rsp,
	ffha_cfg_if.sink     cfg
);
	import ffha_pkg::*;

	localparam int          IW       = $clog2(MAX_SEGMENTS);
	localparam int          CW       = $clog2(MAX_SEGMENTS + 1);
	localparam logic [31:0] HDR      = 32'(HEADER_BYTES);
	localparam logic [31:0] RST_SIZE = HEAP_SIZE_RST - HDR;

	state_t          state_q, state_d;
	logic [31:0]     base_q, size_q;
	logic [CW-1:0]   count_q;
	cmd_t            cmd_q;
	logic [31:0]     reqsz_q, addr_q;
	logic            found_q;
	logic [IW-1:0]   idx_q;
	seg_t            segi_q, segp_q, segn_q;
	logic            rsp_valid_q;
	logic [31:0]     res_addr_q;
	status_t         status_q;

	seg_t            segs [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] hits;
	logic            pk_found;
	logic [IW-1:0]   pk_idx;
	seg_t            pk_i, pk_p, pk_n;
	cell_bc_t        bc;

	logic            req_xfer, cfg_rebuild, apply_go;
	logic [31:0]     cfg_size, rebuild_size;
	logic            split, mprev, mnext;
	logic [31:0]     merged;

	assign req_xfer    = req.valid && req.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_rebuild = cfg.valid && (cfg.index == CFG_HEAP_BASE || cfg.index == CFG_HEAP_SIZE);
	assign cfg_size    = (cfg.index == CFG_HEAP_SIZE) ? cfg.data : size_q;
	assign rebuild_size = (cfg_size >= HDR) ? cfg_size - HDR : '0;
	assign apply_go    = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		split = ({1'b0, segi_q.size} > ({1'b0, reqsz_q} + {1'b0, HDR}))
			&& (count_q < CW'(MAX_SEGMENTS));
		mprev = (idx_q != '0) && !segp_q.used;
		mnext = ((CW'(idx_q) + CW'(1)) < count_q) && !segn_q.used;
		if (mprev && mnext)
			merged = segp_q.size + segi_q.size + segn_q.size + HDR + HDR;
		else if (mprev)
			merged = segp_q.size + segi_q.size + HDR;
		else
			merged = segi_q.size + segn_q.size + HDR;

		bc.cmd         = cmd_q;
		bc.req         = reqsz_q;
		bc.key         = addr_q - base_q - HDR;
		bc.off_new     = segi_q.offset + HDR + reqsz_q;
		bc.size_new    = cfg_rebuild ? rebuild_size : segi_q.size - reqsz_q - HDR;
		bc.size_merged = merged;
		bc.split       = split;
		bc.mprev       = mprev;
		bc.mnext       = mnext;
		if (cfg_rebuild)
			bc.mode = CM_REBUILD;
		else if (state_q == S_MATCH)
			bc.mode = CM_MATCH;
		else if (apply_go && found_q)
			bc.mode = CM_APPLY;
		else
			bc.mode = CM_HOLD;
	end

	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		seg_t nb_prev, nb_next1, nb_next2;
		if (j == 0) begin : g_p0
			assign nb_prev = '0;
		end else begin : g_p
			assign nb_prev = segs[j-1];
		end
		if (j + 1 < MAX_SEGMENTS) begin : g_n1
			assign nb_next1 = segs[j+1];
		end else begin : g_n1z
			assign nb_next1 = '0;
		end
		if (j + 2 < MAX_SEGMENTS) begin : g_n2
			assign nb_next2 = segs[j+2];
		end else begin : g_n2z
			assign nb_next2 = '0;
		end
		ffha_cell #(
			.IDX(j), .IW(IW), .CW(CW), .RST_SIZE(RST_SIZE)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .bc(bc), .idx(idx_q), .count(count_q),
			.prev(nb_prev), .next1(nb_next1), .next2(nb_next2),
			.seg(segs[j]), .hit(hits[j])
		);
	end

	ffha_pick #(.N(MAX_SEGMENTS), .IW(IW)) u_pick (
		.hits(hits), .segs(segs), .found(pk_found), .idx(pk_idx),
		.seg_i(pk_i), .seg_prev(pk_p), .seg_next(pk_n)
	);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					state_d = S_MATCH;
			end
			S_MATCH: state_d = S_PICK;
			S_PICK:  state_d = S_APPLY;
			S_APPLY: begin
				if (apply_go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= HEAP_SIZE_RST;
			count_q <= CW'(1);
		end else begin
			if (cfg.valid && cfg.index == CFG_HEAP_BASE)
				base_q <= cfg.data;
			if (cfg.valid && cfg.index == CFG_HEAP_SIZE)
				size_q <= cfg.data;
			if (cfg_rebuild)
				count_q <= CW'(1);
			else if (apply_go && found_q) begin
				if (cmd_q == CMD_ALLOC) begin
					if (split)
						count_q <= count_q + CW'(1);
				end else if (mprev && mnext)
					count_q <= count_q - CW'(2);
				else if (mprev || mnext)
					count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q   <= cmd_t'(req.command);
			reqsz_q <= req.request_size;
			addr_q  <= req.free_address;
		end
		if (state_q == S_PICK) begin
			found_q <= pk_found;
			idx_q   <= pk_idx;
			segi_q  <= pk_i;
			segp_q  <= pk_p;
			segn_q  <= pk_n;
		end
		if (apply_go) begin
			if (cmd_q == CMD_ALLOC && found_q)
				res_addr_q <= base_q + segi_q.offset + HDR;
			else
				res_addr_q <= '0;
			if (found_q)
				status_q <= STS_OK;
			else if (cmd_q == CMD_ALLOC)
				status_q <= STS_NO_FIT;
			else
				status_q <= STS_NOT_ALLOC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (apply_go)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_address = res_addr_q;
	assign rsp.status         = status_q;

	`FFHA_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, (count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
	`FFHA_ASSERT_NEXT(a_accept_match, clk, arst_n, req_xfer, state_q == S_MATCH)
	`FFHA_ASSERT_NOW(a_rsp_from_apply, clk, arst_n, $rose(rsp_valid_q), $past(state_q) == S_APPLY)

endmodule

`default_nettype wire

### dv/first_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests against a shadow segment table and
// checks every response transfer, across several heap settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class alloc_scoreboard;
	localparam int MAX_SEG = ffha_pkg::MAX_SEGMENTS_DEF;
	localparam logic [31:0] HDR = ffha_pkg::HEADER_BYTES_DEF;

	logic [31:0] base;
	logic [31:0] hsize;
	logic [31:0] seg_off [MAX_SEG];
	logic [31:0] seg_size [MAX_SEG];
	bit          seg_used [MAX_SEG];
	int          seg_cnt;
	logic [31:0] exp_addr [$];
	ffha_pkg::status_t exp_sts [$];
	int          errors;
	// Payload addresses currently handed out, for realistic frees.
	logic [31:0] live [$];

	function new();
		errors = 0;
		base = '0;
		hsize = ffha_pkg::HEAP_SIZE_RST;
		rebuild();
	endfunction

	function void rebuild();
		for (int i = 0; i < MAX_SEG; i++) begin
			seg_off[i] = '0;
			seg_size[i] = '0;
			seg_used[i] = 0;
		end
		seg_size[0] = (hsize >= HDR) ? hsize - HDR : '0;
		seg_cnt = 1;
		live.delete();
	endfunction

	function void write_reg(ffha_pkg::cfg_idx_t idx, logic [31:0] val);
		if (idx == ffha_pkg::CFG_HEAP_BASE)
			base = val;
		else
			hsize = val;
		rebuild();
	endfunction

	function logic [31:0] payload(int k);
		return base + seg_off[k] + HDR;
	endfunction

	function void drop(int k);
		for (int j = k; j + 1 < seg_cnt; j++) begin
			seg_off[j] = seg_off[j + 1];
			seg_size[j] = seg_size[j + 1];
			seg_used[j] = seg_used[j + 1];
		end
		seg_cnt--;
	endfunction

	function void note_request(ffha_pkg::cmd_t cmd, logic [31:0] rsz, logic [31:0] fa);
		int i;
		i = 0;
		if (cmd == ffha_pkg::CMD_ALLOC) begin
			while (i < seg_cnt && (seg_used[i] || seg_size[i] <= rsz))
				i++;
			if (i == seg_cnt) begin
				exp_addr.push_back('0);
				exp_sts.push_back(ffha_pkg::STS_NO_FIT);
				return;
			end
			if ({1'b0, seg_size[i]} <= {1'b0, rsz} + 33'(HDR) || seg_cnt >= MAX_SEG) begin
				seg_used[i] = 1;
			end else begin
				for (int j = seg_cnt; j > i + 1; j--) begin
					seg_off[j] = seg_off[j - 1];
					seg_size[j] = seg_size[j - 1];
					seg_used[j] = seg_used[j - 1];
				end
				seg_off[i + 1] = seg_off[i] + HDR + rsz;
				seg_size[i + 1] = seg_size[i] - rsz - HDR;
				seg_used[i + 1] = 0;
				seg_size[i] = rsz;
				seg_used[i] = 1;
				seg_cnt++;
			end
			exp_addr.push_back(payload(i));
			exp_sts.push_back(ffha_pkg::STS_OK);
			live.push_back(payload(i));
		end else begin
			while (i < seg_cnt && !(seg_used[i] && payload(i) == fa))
				i++;
			exp_addr.push_back('0);
			if (i == seg_cnt) begin
				exp_sts.push_back(ffha_pkg::STS_NOT_ALLOC);
				return;
			end
			exp_sts.push_back(ffha_pkg::STS_OK);
			seg_used[i] = 0;
			if (i > 0 && !seg_used[i - 1]) begin
				seg_size[i - 1] = seg_size[i - 1] + seg_size[i] + HDR;
				drop(i);
				i--;
			end
			if (i + 1 < seg_cnt && !seg_used[i + 1]) begin
				seg_size[i] = seg_size[i] + seg_size[i + 1] + HDR;
				drop(i + 1);
			end
			foreach (live[k])
				if (live[k] == fa) begin
					live.delete(k);
					break;
				end
		end
	endfunction

	function void check_response(logic [31:0] addr, logic [1:0] sts);
		if (exp_addr.size() == 0) begin
			$error("unexpected response: result_address %h status %0d", addr, sts);
			errors++;
			return;
		end
		if (addr !== exp_addr[0]) begin
			$error("result_address: expected %h, actual %h", exp_addr[0], addr);
			errors++;
		end
		if (sts !== exp_sts[0]) begin
			$error("status: expected %0d, actual %0d", exp_sts[0], sts);
			errors++;
		end
		void'(exp_addr.pop_front());
		void'(exp_sts.pop_front());
	endfunction
endclass

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	ffha_req_if req ();
	ffha_rsp_if rsp ();
	ffha_cfg_if cfg ();

	alloc_scoreboard sb;
	bit   hold_off;
	int   idle_cycles;

	first_fit_heap_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// Valid stays high after a transfer so that the next request can follow
	// at once; it is dropped only when a gap or a drain follows.
	task automatic send_request(cmd_t cmd, logic [31:0] rsz, logic [31:0] fa, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			req.valid <= 1'b0;
			wait_cycles(g);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.request_size <= rsz;
		req.free_address <= fa;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(cmd, rsz, fa);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.exp_addr.size() != 0)
			@(posedge clk);
		// Responses are registered; allow the pipeline to settle.
		wait_cycles(8);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_request(bit gaps);
		int r;
		logic [31:0] fa;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			if ($urandom_range(0, 9) == 0)
				send_request(CMD_ALLOC, $urandom(), $urandom(), gaps);
			else
				send_request(CMD_ALLOC, $urandom_range(0, 600), $urandom(), gaps);
		end else if (r < 90 && sb.live.size() != 0) begin
			fa = sb.live[$urandom_range(0, sb.live.size() - 1)];
			send_request(CMD_FREE, $urandom(), fa, gaps);
		end else begin
			send_request(CMD_FREE, $urandom(), $urandom(), gaps);
		end
	endtask

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp.ready <= 1'b0;
				wait_cycles(300);
				hold_off = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				wait_cycles(gap_len() + 1);
			end else begin
				rsp.ready <= 1'b1;
				wait_cycles($urandom_range(1, 12));
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(rsp.result_address, rsp.status);

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		hold_off = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = 1'b0;
		req.request_size = '0;
		req.free_address = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		wait_cycles(3);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, both commands, bad and double frees.
		send_request(CMD_ALLOC, 32'hFFFF_FFFF, '0, 0);
		send_request(CMD_ALLOC, '0, 32'hFFFF_FFFF, 0);
		send_request(CMD_ALLOC, 32'd100, '0, 0);
		send_request(CMD_ALLOC, 32'd65000, '0, 0);
		send_request(CMD_FREE, '0, 32'd16, 0);
		send_request(CMD_FREE, '0, 32'd16, 0);
		send_request(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_request(CMD_ALLOC, 32'd65503, '0, 0);
		send_request(CMD_FREE, '0, 32'd16, 0);
		send_request(CMD_FREE, '0, 32'd48, 0);
		// Small heap: nothing ever fits.
		write_reg(CFG_HEAP_SIZE, 32'd5);
		send_request(CMD_ALLOC, '0, '0, 0);
		// Address wrap near the top of the space.
		write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF8);
		write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
		send_request(CMD_ALLOC, 32'd0, '0, 0);
		send_request(CMD_ALLOC, 32'hFFFF_FF00, '0, 0);
		send_request(CMD_FREE, '0, 32'h0000_0008, 0);
		// Full table: single-byte allocations until the table runs out.
		write_reg(CFG_HEAP_SIZE, 32'd4096);
		for (int i = 0; i < 70; i++)
			send_request(CMD_ALLOC, 32'd1, '0, 0);
		write_reg(CFG_HEAP_BASE, 32'h8000_0000);

		// Random phases with several heap settings.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_reg(CFG_HEAP_SIZE, 32'd2048);
				2: write_reg(CFG_HEAP_BASE, $urandom());
				3: write_reg(CFG_HEAP_SIZE, '0);
				4: write_reg(CFG_HEAP_SIZE, 32'd16384);
				default: ;
			endcase
			for (int n = 0; n < 200; n++) begin
				if (ph == 1 && n == 20) begin
					// Long response hold-off while requests keep coming.
					hold_off = 1;
				end
				if (ph == 2 && n == 100) begin
					// Pause until every outstanding response has arrived.
					drain();
				end
				random_request(n % 50 > 10);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
